FILE: design/mavg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average package
// Shared widths, item and control types, and the back-end state encoding.
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int DATA_W      = 32;
    localparam int WL_W        = 7;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W       = DATA_W + PTR_W;
    localparam int ITER_W      = $clog2(SUM_W + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_W   = APB_AW - 2;

    localparam logic [WL_W-1:0]      WL_RESET          = WL_W'(50);
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = '0;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     invalid;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        logic             restart;
        logic [LEN_W-1:0] eff_len;
    } t_cfg;

    typedef struct packed {
        logic [LEN_W-1:0] held_count;
        logic [PTR_W-1:0] wr_ptr;
    } t_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_UPDATE,
        BK_DIV_INIT,
        BK_DIVIDE,
        BK_DONE
    } t_back_state;

    // A length of zero acts as one, and anything above the ring depth is clamped.
    function automatic logic [LEN_W-1:0] eff_len(input logic [WL_W-1:0] wl);
        logic [LEN_W-1:0] len;
        if (wl == '0) begin
            len = LEN_W'(1);
        end else if (int'(wl) > MAX_WINDOW) begin
            len = LEN_W'(MAX_WINDOW);
        end else begin
            len = LEN_W'(wl);
        end
        return len;
    endfunction

endpackage
`default_nettype wire

FILE: design/mavg_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one sample item and its invalid flag.
// ----------------------------------------------------------------------------
interface mavg_in_if import mavg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;
    logic                     sample_invalid;

    modport source (output valid, output sample, output sample_invalid, input ready);
    modport sink   (input valid, input sample, input sample_invalid, output ready);
endinterface
`default_nettype wire

FILE: design/mavg_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Average channel
// Valid/ready channel that carries one average item and its invalid flag.
// ----------------------------------------------------------------------------
interface mavg_out_if import mavg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] average;
    logic                     average_invalid;

    modport source (output valid, output average, output average_invalid, input ready);
    modport sink   (input valid, input average, input average_invalid, output ready);
endinterface
`default_nettype wire

FILE: design/mavg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mavg_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: design/mavg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average front end
// Accepts sample items with their invalid flags and queues them.
// ----------------------------------------------------------------------------
module mavg_front import mavg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mavg_in_if.sink   i_in,
    output t_head     o_head,
    input  wire logic i_pop
);

    t_item             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_idx;
    logic [QPTR_W-1:0] r_rd_idx;
    logic [QCNT_W-1:0] r_fill;
    logic              w_push;
    logic              w_pop;

    assign i_in.ready = (r_fill != QCNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_fill != '0);

    assign o_head.valid = (r_fill != '0);
    assign o_head.item  = r_slot[r_rd_idx];

    // The queue depth is a power of two, so the indices wrap by themselves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_idx <= r_wr_idx + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_idx <= r_rd_idx + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_idx].sample  <= i_in.sample;
            r_slot[r_wr_idx].invalid <= i_in.sample_invalid;
        end
    end

endmodule
`default_nettype wire

FILE: design/mavg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average back end
// Updates the sample ring and running sum, divides by the held count; echoes invalid items.
// ----------------------------------------------------------------------------
module mavg_back import mavg_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire t_head i_head,
    output logic       o_pop,
    output t_status    o_status,
    mavg_out_if.source o_out
);

    t_back_state              r_state, n_state;
    logic [LEN_W-1:0]         r_count, n_count;
    logic [PTR_W-1:0]         r_wr_ptr, n_wr_ptr;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    t_item                    r_item, n_item;
    logic                     r_neg, n_neg;
    logic [SUM_W-1:0]         r_quot, n_quot;
    logic [LEN_W:0]           r_rem, n_rem;
    logic [ITER_W-1:0]        r_iter, n_iter;
    logic                     r_out_valid, n_out_valid;
    logic [DATA_W-1:0]        r_out_average, n_out_average;
    logic                     r_out_invalid, n_out_invalid;

    logic                     w_ram_wr_en;
    logic                     w_ram_rd_en;
    logic [DATA_W-1:0]        w_ram_rd_data;
    logic [LEN_W:0]           w_shifted;
    logic [DATA_W-1:0]        w_quot_low;

    mavg_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (r_item.sample),
        .i_rd_en   (w_ram_rd_en),
        .i_rd_addr (r_wr_ptr),
        .o_rd_data (w_ram_rd_data)
    );

    assign w_shifted  = {r_rem[LEN_W-1:0], r_quot[SUM_W-1]};
    assign w_quot_low = r_quot[DATA_W-1:0];

    assign o_status.held_count = r_count;
    assign o_status.wr_ptr     = r_wr_ptr;
    assign o_out.valid           = r_out_valid;
    assign o_out.average         = r_out_average;
    assign o_out.average_invalid = r_out_invalid;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_wr_ptr      = r_wr_ptr;
        n_sum         = r_sum;
        n_item        = r_item;
        n_neg         = r_neg;
        n_quot        = r_quot;
        n_rem         = r_rem;
        n_iter        = r_iter;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_average = r_out_average;
        n_out_invalid = r_out_invalid;
        o_pop         = 1'b0;
        w_ram_wr_en   = 1'b0;
        w_ram_rd_en   = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop  = 1'b1;
                    n_item = i_head.item;
                    n_state = i_head.item.invalid ? BK_DONE : BK_READ;
                end
            end
            BK_READ: begin
                // Fetch the oldest sample while the new one enters the sum.
                w_ram_rd_en = 1'b1;
                n_sum = r_sum + {{PTR_W{r_item.sample[DATA_W-1]}}, r_item.sample};
                n_state = BK_UPDATE;
            end
            BK_UPDATE: begin
                w_ram_wr_en = 1'b1;
                if (r_count >= i_cfg.eff_len) begin
                    n_sum = r_sum - {{PTR_W{w_ram_rd_data[DATA_W-1]}}, w_ram_rd_data};
                end else begin
                    n_count = r_count + LEN_W'(1);
                end
                if (LEN_W'(r_wr_ptr) + LEN_W'(1) >= i_cfg.eff_len) begin
                    n_wr_ptr = '0;
                end else begin
                    n_wr_ptr = r_wr_ptr + PTR_W'(1);
                end
                n_state = BK_DIV_INIT;
            end
            BK_DIV_INIT: begin
                // Divide the magnitude and restore the sign at the end.
                n_neg  = r_sum[SUM_W-1];
                n_quot = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
                n_rem  = '0;
                n_iter = '0;
                n_state = BK_DIVIDE;
            end
            BK_DIVIDE: begin
                if (w_shifted >= {1'b0, r_count}) begin
                    n_rem  = w_shifted - {1'b0, r_count};
                    n_quot = {r_quot[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem  = w_shifted;
                    n_quot = {r_quot[SUM_W-2:0], 1'b0};
                end
                n_iter = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(SUM_W - 1)) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_invalid = r_item.invalid;
                    if (r_item.invalid) begin
                        n_out_average = r_item.sample;
                    end else if (r_neg) begin
                        n_out_average = -w_quot_low;
                    end else begin
                        n_out_average = w_quot_low;
                    end
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (i_cfg.restart) begin
            n_count  = '0;
            n_wr_ptr = '0;
            n_sum    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_wr_ptr    <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wr_ptr    <= n_wr_ptr;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item        <= n_item;
        r_neg         <= n_neg;
        r_quot        <= n_quot;
        r_rem         <= n_rem;
        r_iter        <= n_iter;
        r_out_average <= n_out_average;
        r_out_invalid <= n_out_invalid;
    end

endmodule
`default_nettype wire

FILE: design/moving_average_window_top.sv
`default_nettype none
// Path: a valid sample item passes the back-end states read, update, divide set-up, a
// 38-step shift-subtract divide, and done, where its result enters the output register; an
// invalid item goes from idle straight to done and is echoed. The back end takes one item
// at a time; a 2-entry queue keeps accepting items meanwhile.
// Reset: window length 50, empty window (count, write pointer and sum zero); the sample ring
// is not cleared, since only entries written since the last restart are ever read.
// ----------------------------------------------------------------------------
// Moving average window, top level
// Boxcar average over the most recent valid samples, with an APB register port.
// ----------------------------------------------------------------------------
module moving_average_window_top import mavg_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    mavg_in_if.sink                i_in,
    mavg_out_if.source             o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    // The raw register value is kept for read-back; the clamped length is what the
    // back end works with, so the clamp costs nothing on the item path.
    logic [WL_W-1:0]  r_win_len;
    logic [LEN_W-1:0] r_eff_len;
    logic             w_reg_hit;
    logic             w_cfg_write;
    t_cfg             w_cfg;
    t_head            w_head;
    logic             w_pop;
    t_status          w_status;

    assign pready      = 1'b1;
    assign w_reg_hit   = (paddr[APB_AW-1:2] == REG_WINDOW_LENGTH);
    assign w_cfg_write = psel && penable && pwrite && pready && w_reg_hit;
    assign prdata      = w_reg_hit ? APB_DW'(r_win_len) : '0;

    // Any write to the window length restarts an empty window in the same cycle.
    assign w_cfg.restart = w_cfg_write;
    assign w_cfg.eff_len = r_eff_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= WL_RESET;
            r_eff_len <= eff_len(WL_RESET);
        end else if (w_cfg_write) begin
            r_win_len <= pwdata[WL_W-1:0];
            r_eff_len <= eff_len(pwdata[WL_W-1:0]);
        end
    end

    // The front end takes items from the channel into a short queue, so that the
    // channel is not held up while the back end is busy dividing, until the queue fills.
    mavg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // The back end updates the ring and running sum, divides, and holds the result
    // in an output register until it is taken.
    mavg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_status (w_status),
        .o_out    (o_out)
    );

`ifndef NO_ASSERTIONS
    a_count_within_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.held_count <= r_eff_len)
        else $error("held count exceeds the window length");

    a_ptr_within_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(w_status.wr_ptr) < r_eff_len)
        else $error("write pointer outside the window");

    a_restart_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg.restart |=> (w_status.held_count == '0) && (w_status.wr_ptr == '0))
        else $error("window not emptied after a length write");
`endif

endmodule
`default_nettype wire

FILE: verif/moving_average_window_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average window testbench
// Drives sample items and window-length writes into the block, predicts every
// average item with an independent boxcar model and checks each one as it
// leaves, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module moving_average_window_top_tb;
    import mavg_pkg::*;

    // Cycles to wait after the last average item.
    localparam int DRAIN_CYCLES   = 60;
    // Cycles without any accepted item or register access before giving up.
    // The longest legal quiet spell is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_ITEMS     = 24;
    localparam int SEGS_PER_PHASE = 4;

    typedef struct packed {
        logic signed [DATA_W-1:0] average;
        logic                     average_invalid;
    } t_avg_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    mavg_in_if  sample_if ();
    mavg_out_if avg_if ();

    moving_average_window_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_if),
        .o_out   (avg_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Boxcar predictor state. It mirrors what the block must hold: the ring of
    // stored samples, how many are held, where the next one goes and their sum.
    // ------------------------------------------------------------------------
    logic [WL_W-1:0] win_len_reg;
    int              win_ring [MAX_WINDOW];
    int              win_held;
    int              win_wptr;
    longint          win_sum;

    // Averages still owed by the block, oldest first.
    t_avg_item expected_avg_q [$];
    t_avg_item oldest_expected;

    // Idling controls, in percent, shared by the sender task and the receiver.
    int send_idle_pct;
    int recv_stall_pct;
    // The receiver loads its own hold-off counter when asked to.
    bit hold_request;
    int hold_left;

    int n_sent;
    int n_sent_invalid;
    int n_checked;
    int n_length_writes;
    int n_errors;

    // Writing the window length empties the window; the ring contents need not
    // be cleared since only entries written since then are ever read.
    function automatic void restart_window();
        win_held = 0;
        win_wptr = 0;
        win_sum  = 0;
    endfunction

    // Work out the average item that one accepted sample item must produce,
    // and advance the window when the sample is valid.
    function automatic t_avg_item predict_average(input logic signed [DATA_W-1:0] smp,
                                                  input logic                     inv);
        t_avg_item res;
        int        len;
        int        slot;
        longint    mean;
        // An invalid sample is echoed and leaves the window alone.
        if (inv) begin
            res.average         = smp;
            res.average_invalid = 1'b1;
            return res;
        end
        // A length of zero behaves as one, anything beyond the ring as the ring.
        len = int'(win_len_reg);
        if (len == 0) begin
            len = 1;
        end else if (len > MAX_WINDOW) begin
            len = MAX_WINDOW;
        end
        slot = (win_wptr >= len) ? 0 : win_wptr;
        // Once full, the oldest sample sits in the slot about to be overwritten.
        if (win_held >= len) begin
            win_sum  = win_sum - longint'(win_ring[slot]);
            win_held = len;
        end else begin
            win_held++;
        end
        win_ring[slot] = int'(smp);
        win_sum        = win_sum + longint'(smp);
        slot++;
        win_wptr = (slot >= len) ? 0 : slot;
        // Integer division of a signed value truncates toward zero.
        mean                = win_sum / longint'(win_held);
        res.average         = mean[DATA_W-1:0];
        res.average_invalid = 1'b0;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Register port. A transfer has a setup phase and an access phase; the
    // access completes at the rising edge that follows pready being seen high.
    // ------------------------------------------------------------------------
    task automatic apb_access(input  bit                   wr,
                              input  logic [REG_IDX_W-1:0] idx,
                              input  logic [APB_DW-1:0]    wdata,
                              output logic [APB_DW-1:0]    rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        rdata = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_window_length(input logic [WL_W-1:0] want);
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, REG_WINDOW_LENGTH, '0, rd);
        if (rd !== APB_DW'(want)) begin
            $error("window_length readback: expected %0d, actual %0d", want, rd);
            n_errors++;
        end
    endtask

    // Only the low bits land in the register; the rest of the word is ignored.
    task automatic write_window_length(input logic [APB_DW-1:0] wdata);
        logic [APB_DW-1:0] rd;
        apb_access(1'b1, REG_WINDOW_LENGTH, wdata, rd);
        win_len_reg = wdata[WL_W-1:0];
        restart_window();
        n_length_writes++;
        check_window_length(wdata[WL_W-1:0]);
    endtask

    // ------------------------------------------------------------------------
    // Sample sender. Offers one item, idling first at the current rate, and
    // records the expected average once the item has been taken. Ready is
    // looked at on the falling edge, where it is settled for the next rise.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic signed [DATA_W-1:0] smp, input logic inv);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_if.valid          <= 1'b1;
        sample_if.sample         <= smp;
        sample_if.sample_invalid <= inv;
        do @(negedge i_clk); while (!sample_if.ready);
        @(posedge i_clk);
        expected_avg_q.insert(expected_avg_q.size(), predict_average(smp, inv));
        n_sent++;
        if (inv) begin
            n_sent_invalid++;
        end
    endtask

    // Stop offering and wait for every owed average. Every item yields exactly
    // one average, so the block is idle once the queue is empty.
    task automatic pause_sender();
        sample_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_avg_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random samples lean towards the extremes, near-full-scale runs that push
    // the sum towards its limits, and small values where truncation shows.
    function automatic logic signed [DATA_W-1:0] random_sample();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = '0;
                    3: v = -32'sd1;
                    default: v = 32'sd1;
                endcase
            end
            1, 2: v = $signed(DATA_W'($urandom_range(2000))) - 32'sd1000;
            3, 4: v = 32'sh7FFF_0000 | DATA_W'($urandom_range(16'hFFFF));
            5: v = 32'sh8000_0000 | DATA_W'($urandom_range(16'hFFFF));
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: stalls at random, or holds off completely for a counted
    // stretch when a test asks, so that the block fills and stops taking items.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            avg_if.ready <= 1'b0;
            hold_left--;
        end else begin
            avg_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Each average item taken is compared with the oldest one owed. Valid and
    // ready are settled on the falling edge, ahead of the rise that takes it.
    always @(negedge i_clk) begin
        if (i_rst_n && avg_if.valid && avg_if.ready) begin
            if (expected_avg_q.size() == 0) begin
                $error("average item with none expected: average %0d, average_invalid %0b",
                       avg_if.average, avg_if.average_invalid);
                n_errors++;
            end else begin
                oldest_expected = expected_avg_q[0];
                expected_avg_q.delete(0);
                n_checked++;
                if (avg_if.average !== oldest_expected.average) begin
                    $error("average: expected %0d, actual %0d",
                           oldest_expected.average, avg_if.average);
                    n_errors++;
                end
                if (avg_if.average_invalid !== oldest_expected.average_invalid) begin
                    $error("average_invalid: expected %0b, actual %0b",
                           oldest_expected.average_invalid, avg_if.average_invalid);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: too long without any item moving or any register access.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((sample_if.valid && sample_if.ready) || (avg_if.valid && avg_if.ready) || psel) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timed out after %0d quiet cycles with %0d averages owed.",
                 WATCHDOG_LIMIT, expected_avg_q.size());
        $display("** moving_average_window_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked items: full-scale values, truncation of negative means,
    // invalid echoes, a zero length, a short window that wraps, and a window
    // that averages to the most negative value.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        check_window_length(WL_RESET);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(-32'sd1, 1'b0);
        // The sum is now -7 over four samples: truncation gives -1, not -2.
        send_sample(-32'sd5, 1'b0);
        send_sample(32'sh8000_0000, 1'b1);
        send_sample(32'sh7FFF_FFFF, 1'b1);
        send_sample('0, 1'b1);
        pause_sender();
        // A zero length behaves as a window of one.
        write_window_length('0);
        send_sample(32'sd5, 1'b0);
        send_sample(-32'sd7, 1'b0);
        send_sample(32'sh1234_5678, 1'b1);
        send_sample(32'sd9, 1'b0);
        pause_sender();
        // A window of three fills, then drops its oldest sample on each item.
        write_window_length(APB_DW'(3));
        send_sample(32'sd10, 1'b0);
        send_sample(32'sd20, 1'b0);
        send_sample(32'sd30, 1'b0);
        send_sample(32'sd40, 1'b0);
        send_sample(-32'sd100, 1'b0);
        send_sample(-32'sd101, 1'b0);
        pause_sender();
        write_window_length(APB_DW'(2));
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        pause_sender();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the internal queue fills and the input stalls; the sender
    // then waits until every owed average has come out.
    task automatic test_receiver_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_window_length(APB_DW'(4));
        hold_request = 1'b1;
        repeat (HOLD_ITEMS) begin
            send_sample(random_sample(), ($urandom_range(7) == 0));
        end
        pause_sender();
    endtask

    // Random items under four idling patterns, each with several window
    // lengths. The first lengths are the extremes: one, the full ring, zero,
    // the largest register value, just past the ring, two, and one short of
    // the ring. Segments are long enough for the largest window to wrap.
    task automatic test_random_windows();
        logic [WL_W-1:0]   picks [7] = '{1, 64, 0, 127, 65, 2, 63};
        logic [WL_W-1:0]   wl;
        logic [APB_DW-1:0] word;
        int                seg;
        seg = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            for (int k = 0; k < SEGS_PER_PHASE; k++) begin
                pause_sender();
                wl = (seg < 7) ? picks[seg] : WL_W'($urandom_range(127));
                // Half the time the unused upper bits of the word carry junk.
                word = $urandom_range(1) ? $urandom() : '0;
                word[WL_W-1:0] = wl;
                write_window_length(word);
                repeat ($urandom_range(70, 95)) begin
                    send_sample(random_sample(), ($urandom_range(9) == 0));
                end
                seg++;
            end
        end
        pause_sender();
    endtask

    initial begin
        i_rst_n                  = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        sample_if.valid          = 1'b0;
        sample_if.sample         = '0;
        sample_if.sample_invalid = 1'b0;
        avg_if.ready             = 1'b0;
        hold_request             = 1'b0;
        hold_left                = 0;
        send_idle_pct            = 0;
        recv_stall_pct           = 0;
        n_sent                   = 0;
        n_sent_invalid           = 0;
        n_checked                = 0;
        n_length_writes          = 0;
        n_errors                 = 0;
        win_len_reg              = WL_RESET;
        restart_window();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_receiver_hold_off();
        test_random_windows();

        // Everything has been answered; leave time for any stray average item.
        pause_sender();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d sample items (%0d flagged invalid) and %0d averages checked,",
                 n_sent, n_sent_invalid, n_checked);
        $display("over %0d window-length writes under four idling patterns and one long hold-off.",
                 n_length_writes);
        if (n_errors == 0 && expected_avg_q.size() == 0) begin
            $display("** moving_average_window_top: PASSED **");
        end else begin
            $display("%0d mismatches, %0d averages never arrived.", n_errors,
                     expected_avg_q.size());
            $display("** moving_average_window_top: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/mavg_pkg.sv
design/mavg_in_if.sv
design/mavg_out_if.sv
design/mavg_ram.sv
design/mavg_front.sv
design/mavg_back.sv
design/moving_average_window_top.sv
verif/moving_average_window_top_tb.sv
